/* rtl/sulq_pkg.sv */
`default_nettype none

package sulq_pkg;

	// Number of values the store can hold.
	localparam int DEPTH = 16;

	// Index and count widths that follow from the depth.
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam int VAL_W   = 16;
	localparam int ENTRY_W = 5;

	// Largest value reported while the store is empty.
	localparam logic signed [VAL_W-1:0] EMPTY_LARGEST = 16'sd9999;

	typedef logic [IDX_W-1:0]          idx_t;
	typedef logic [CNT_W-1:0]          cnt_t;
	typedef logic [ENTRY_W-1:0]        entry_t;
	typedef logic signed [VAL_W-1:0]   val_t;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_DUP   = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef struct packed {
		op_t  op;
		val_t value;
	} in_word_t;

	typedef struct packed {
		status_t status;
		val_t    removed_value;
		val_t    largest_value;
		entry_t  entry_count;
	} out_word_t;

	// One access of the value store per cycle on each port.
	typedef struct packed {
		logic wr_en;
		idx_t wr_addr;
		val_t wr_data;
		logic rd_en;
		idx_t rd_addr;
	} mem_req_t;

	// Held count reported modulo 2**ENTRY_W.
	function automatic entry_t to_entry_count(input cnt_t c);
		return entry_t'(c);
	endfunction

endpackage

`default_nettype wire

/* rtl/sulq_store.sv */
`default_nettype none

// Value store: one write port and one read port with registered read data.
module sulq_store (
	input  wire logic              clk,
	input  wire sulq_pkg::mem_req_t req,
	output sulq_pkg::val_t         rd_data
);

	sulq_pkg::val_t mem_q [sulq_pkg::DEPTH];
	sulq_pkg::val_t rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem_q[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

/* rtl/sulq_seq.sv */
`default_nettype none

// Sequencer that walks the value store one entry at a time through a single
// compare unit.
module sulq_seq (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire sulq_pkg::in_word_t   in_data,
	output logic                      res_valid,
	input  wire logic                 res_ready,
	output sulq_pkg::out_word_t       res_data,
	output sulq_pkg::mem_req_t        mem_req,
	input  wire sulq_pkg::val_t       rd_data
);

	typedef enum logic [12:0] {
		S_IDLE    = 13'b0000000000001,
		S_SCAN    = 13'b0000000000010,
		S_CMP     = 13'b0000000000100,
		S_DECIDE  = 13'b0000000001000,
		S_SHIFT   = 13'b0000000010000,
		S_SHIFTW  = 13'b0000000100000,
		S_POPRD   = 13'b0000001000000,
		S_POP     = 13'b0000010000000,
		S_PSHIFT  = 13'b0000100000000,
		S_PSHIFTW = 13'b0001000000000,
		S_LAST    = 13'b0010000000000,
		S_LASTW   = 13'b0100000000000,
		S_DONE    = 13'b1000000000000
	} state_t;

	state_t             state_q;
	sulq_pkg::op_t      op_q;
	sulq_pkg::val_t     value_q;
	sulq_pkg::cnt_t     count_q;
	sulq_pkg::cnt_t     pos_q;
	sulq_pkg::cnt_t     idx_q;
	sulq_pkg::status_t  status_q;
	sulq_pkg::val_t     removed_q;
	sulq_pkg::val_t     largest_q;

	sulq_pkg::cnt_t     idx_m1;
	sulq_pkg::cnt_t     count_m1;
	logic               lt;
	logic               eq;

	assign idx_m1   = idx_q - sulq_pkg::cnt_t'(1);
	assign count_m1 = count_q - sulq_pkg::cnt_t'(1);

	// The shared compare unit: stored value against the value to insert.
	assign lt = (rd_data < value_q);
	assign eq = (rd_data == value_q);

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);

	assign res_data.status        = status_q;
	assign res_data.removed_value = removed_q;
	assign res_data.largest_value = largest_q;
	assign res_data.entry_count   = sulq_pkg::to_entry_count(count_q);

	always_comb begin
		mem_req = '0;
		case (state_q)
			S_SCAN: begin
				mem_req.rd_en   = (pos_q < count_q);
				mem_req.rd_addr = pos_q[sulq_pkg::IDX_W-1:0];
			end
			S_SHIFT: begin
				if (idx_q > pos_q) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = idx_m1[sulq_pkg::IDX_W-1:0];
				end else begin
					mem_req.wr_en   = 1'b1;
					mem_req.wr_addr = pos_q[sulq_pkg::IDX_W-1:0];
					mem_req.wr_data = value_q;
				end
			end
			S_SHIFTW: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = idx_q[sulq_pkg::IDX_W-1:0];
				mem_req.wr_data = rd_data;
			end
			S_POPRD: begin
				mem_req.rd_en   = (count_q != '0);
				mem_req.rd_addr = '0;
			end
			S_PSHIFT: begin
				mem_req.rd_en   = (idx_q < count_q);
				mem_req.rd_addr = idx_q[sulq_pkg::IDX_W-1:0];
			end
			S_PSHIFTW: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = idx_m1[sulq_pkg::IDX_W-1:0];
				mem_req.wr_data = rd_data;
			end
			S_LAST: begin
				mem_req.rd_en   = (count_q != '0);
				mem_req.rd_addr = count_m1[sulq_pkg::IDX_W-1:0];
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						case (in_data.op)
							sulq_pkg::OP_INSERT: state_q <= S_SCAN;
							sulq_pkg::OP_REMOVE: state_q <= S_POPRD;
							sulq_pkg::OP_CLEAR: begin
								count_q <= '0;
								state_q <= S_LAST;
							end
							default: state_q <= S_LAST;
						endcase
					end
				end
				S_SCAN: begin
					state_q <= (pos_q < count_q) ? S_CMP : S_DECIDE;
				end
				S_CMP: begin
					if (lt) begin
						state_q <= S_SCAN;
					end else if (eq) begin
						state_q <= S_LAST;
					end else begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					state_q <= (count_q >= sulq_pkg::cnt_t'(sulq_pkg::DEPTH)) ? S_LAST : S_SHIFT;
				end
				S_SHIFT: begin
					if (idx_q > pos_q) begin
						state_q <= S_SHIFTW;
					end else begin
						count_q <= count_q + sulq_pkg::cnt_t'(1);
						state_q <= S_LAST;
					end
				end
				S_SHIFTW: state_q <= S_SHIFT;
				S_POPRD: state_q <= (count_q == '0) ? S_LAST : S_POP;
				S_POP: state_q <= S_PSHIFT;
				S_PSHIFT: begin
					if (idx_q < count_q) begin
						state_q <= S_PSHIFTW;
					end else begin
						count_q <= count_m1;
						state_q <= S_LAST;
					end
				end
				S_PSHIFTW: state_q <= S_PSHIFT;
				S_LAST: state_q <= (count_q == '0) ? S_DONE : S_LASTW;
				S_LASTW: state_q <= S_DONE;
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers of the current word; they need no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q      <= in_data.op;
				value_q   <= in_data.value;
				pos_q     <= '0;
				status_q  <= sulq_pkg::ST_DONE;
				removed_q <= '0;
			end
			S_CMP: begin
				if (lt) begin
					pos_q <= pos_q + sulq_pkg::cnt_t'(1);
				end else if (eq) begin
					status_q <= sulq_pkg::ST_DUP;
				end
			end
			S_DECIDE: begin
				if (count_q >= sulq_pkg::cnt_t'(sulq_pkg::DEPTH)) begin
					status_q <= sulq_pkg::ST_FULL;
				end
				idx_q <= count_q;
			end
			S_SHIFTW: idx_q <= idx_m1;
			S_POPRD: begin
				if (count_q == '0) begin
					status_q <= sulq_pkg::ST_EMPTY;
				end
			end
			S_POP: begin
				removed_q <= rd_data;
				idx_q     <= sulq_pkg::cnt_t'(1);
			end
			S_PSHIFTW: idx_q <= idx_q + sulq_pkg::cnt_t'(1);
			S_LAST: begin
				if (count_q == '0) begin
					largest_q <= sulq_pkg::EMPTY_LARGEST;
				end
			end
			S_LASTW: largest_q <= rd_data;
			default: begin
				if (op_q == sulq_pkg::OP_NONE) begin
					status_q <= sulq_pkg::ST_DONE;
				end
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/sorted_unique_list_queue_core.sv */
`default_nettype none

// Sorted unique list queue. The block holds up to sulq_pkg::DEPTH signed
// 16-bit values in ascending order with no duplicates, kept in a small value
// store with one read and one write port. Each input word carries one
// operation: insert a value at its sorted place, remove the smallest value,
// or clear the whole store; an unused operation code changes nothing. Every
// input word yields exactly one result word with the status, the removed
// value (zero unless a remove succeeded), the largest held value (9999 when
// the store is empty) and the number of held values. A sequencer walks the
// store one entry at a time through a single compare unit, and every step
// that moves a value reads it on the read port and then writes it on the
// write port. An insert scans past each smaller value and then shifts each
// larger value up by one place before it stores its value; a duplicate or
// a full store ends the insert without a shift. A remove takes the smallest
// value and shifts each remaining value down by one place.
// The input is not ready while a word is being worked on, but a finished
// result sits in an output register, so the next input word can be taken
// while the previous result still waits on the output.
module sorted_unique_list_queue_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire sulq_pkg::in_word_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output sulq_pkg::out_word_t      out_data
);

	sulq_pkg::mem_req_t  mem_req;
	sulq_pkg::val_t      rd_data;
	sulq_pkg::out_word_t res_data;
	logic                res_valid;
	logic                res_ready;

	logic                out_valid_q;
	sulq_pkg::out_word_t out_data_q;

	sulq_store u_store (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	sulq_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.mem_req   (mem_req),
		.rd_data   (rd_data)
	);

	// The output register takes a new result when it is empty or when its
	// current word is being taken in the same cycle.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= res_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire
